### sv/connection_tracking_table_defines.svh
// assertion macros for the connection tracking table
// used by the top level only, no other dependencies
`ifndef CONNECTION_TRACKING_TABLE_DEFINES_SVH
`define CONNECTION_TRACKING_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CTT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTT_ASSERT(lbl, clk, rst, prop, msg)
`define CTT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### sv/ctt_pkg.sv
// shared types, constants and functions of the connection tracking table
// no dependencies
package ctt_pkg;

   // table geometry, buckets must be a power of two
   localparam int BUCKETS = 512;
   localparam int WAYS = 4;
   localparam int ENTRIES = BUCKETS * WAYS;
   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam int IDX_BITS = $clog2(ENTRIES);
   localparam int FILL_BITS = $clog2(WAYS + 1);
   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam logic [31:0] HASH_MUL = 32'h9e3779b1;

   localparam logic [7:0] FL_FIN = 8'h01;
   localparam logic [7:0] FL_SYN = 8'h02;
   localparam logic [7:0] FL_RST = 8'h04;
   localparam logic [7:0] FL_ACK = 8'h10;

   localparam logic [11:0] COUNT_MAX = 12'd4095;

   // ip protocol numbers
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   // kinds
   localparam logic [1:0] KIND_TCP = 2'd0;
   localparam logic [1:0] KIND_UDP = 2'd1;
   localparam logic [1:0] KIND_ICMP = 2'd2;

   // state codes
   localparam logic [3:0] ST_SYN_SENT = 4'd0;
   localparam logic [3:0] ST_SYN_RECV = 4'd1;
   localparam logic [3:0] ST_ESTABLISHED = 4'd2;
   localparam logic [3:0] ST_FIN_WAIT = 4'd3;
   localparam logic [3:0] ST_CLOSE_WAIT = 4'd4;
   localparam logic [3:0] ST_LAST_ACK = 4'd5;
   localparam logic [3:0] ST_TIME_WAIT = 4'd6;
   localparam logic [3:0] ST_UDP_UNREPLIED = 4'd7;
   localparam logic [3:0] ST_UDP_REPLIED = 4'd8;
   localparam logic [3:0] ST_ICMP = 4'd9;
   localparam logic [3:0] ST_NONE = 4'd10;

   // match classes
   localparam logic [1:0] CLS_UNKNOWN = 2'd0;
   localparam logic [1:0] CLS_NEW = 2'd1;
   localparam logic [1:0] CLS_RELATED = 2'd2;
   localparam logic [1:0] CLS_ESTABLISHED = 2'd3;

   localparam logic REQ_PACKET = 1'b0;
   localparam logic REQ_CREATE = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  protocol;
      logic [7:0]  tcp_flags;
      logic [1:0]  conn_kind;
      logic [3:0]  init_state;
   } ctt_req_type;

   typedef struct packed {
      logic        hit;
      logic        reply_dir;
      logic [3:0]  state_out;
      logic [1:0]  match_class;
      logic        established;
      logic        created;
      logic        bucket_full;
      logic [11:0] conn_count;
   } ctt_rsp_type;

   // result of comparing one stored entry
   typedef struct packed {
      logic       hit;
      logic       rev;
      logic [1:0] kind;
      logic [3:0] next_state;
   } ctt_match_type;

   function automatic logic [1:0] class_of(input logic [3:0] st);
      logic [1:0] cls;
      if (st == ST_ESTABLISHED || st == ST_UDP_REPLIED) cls = CLS_ESTABLISHED;
      else if (st == ST_SYN_SENT || st == ST_SYN_RECV) cls = CLS_RELATED;
      else cls = CLS_NEW;
      return cls;
   endfunction

   function automatic logic is_est(input logic [3:0] st);
      return (st == ST_ESTABLISHED || st == ST_UDP_REPLIED);
   endfunction

   function automatic logic [IDX_BITS-1:0] entry_idx(input logic [BUCKET_BITS-1:0] b,
                                                     input logic [WAY_BITS-1:0] w);
      return IDX_BITS'(b) * IDX_BITS'(WAYS) + IDX_BITS'(w);
   endfunction

endpackage

### sv/ctt_ram.sv
// generic single write, single read memory with registered read data
// no dependencies
module ctt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/ctt_match.sv
// tuple compare and state step unit, shared over the ways of a bucket
// depends on ctt_pkg
module ctt_match (
   input  ctt_pkg::ctt_req_type   req,
   input  logic [63:0]            entry_addr,
   input  logic [39:0]            entry_pp,
   input  logic [5:0]             entry_ks,
   output ctt_pkg::ctt_match_type result
);
   import ctt_pkg::*;

   logic [63:0] fwd_addr, rev_addr;
   logic [39:0] fwd_pp, rev_pp;
   logic        fwd_hit, rev_hit;
   logic [1:0]  kind;
   logic [3:0]  cur, nxt;
   logic [7:0]  fl;

   assign fwd_addr = {req.src_ip, req.dst_ip};
   assign rev_addr = {req.dst_ip, req.src_ip};
   assign fwd_pp = {req.src_port, req.dst_port, req.protocol};
   assign rev_pp = {req.dst_port, req.src_port, req.protocol};
   assign fwd_hit = (entry_addr == fwd_addr) && (entry_pp == fwd_pp);
   assign rev_hit = (entry_addr == rev_addr) && (entry_pp == rev_pp);
   assign kind = entry_ks[5:4];
   assign cur = entry_ks[3:0];
   assign fl = req.tcp_flags;

   always_comb begin
      nxt = cur;
      if (kind == KIND_TCP) begin
         if (fwd_hit) begin
            if (cur == ST_SYN_SENT && fl == (FL_SYN | FL_ACK)) nxt = ST_SYN_RECV;
            else if (cur == ST_SYN_RECV && fl == FL_ACK) nxt = ST_ESTABLISHED;
            else if (cur == ST_ESTABLISHED && fl == FL_FIN) nxt = ST_FIN_WAIT;
            else if (cur == ST_ESTABLISHED && fl == FL_RST) nxt = ST_SYN_SENT;
            else if (cur == ST_FIN_WAIT && fl == FL_ACK) nxt = ST_TIME_WAIT;
         end else begin
            if (cur == ST_SYN_SENT && fl == (FL_SYN | FL_ACK)) nxt = ST_SYN_RECV;
            else if (cur == ST_SYN_SENT && fl == FL_ACK) nxt = ST_ESTABLISHED;
            else if (cur == ST_SYN_RECV && fl == FL_FIN) nxt = ST_CLOSE_WAIT;
            else if (cur == ST_ESTABLISHED && fl == FL_FIN) nxt = ST_CLOSE_WAIT;
            else if (cur == ST_CLOSE_WAIT && fl == FL_FIN) nxt = ST_LAST_ACK;
         end
      end else if (kind == KIND_UDP && !fwd_hit) begin
         nxt = ST_UDP_REPLIED;
      end
   end

   assign result.hit = fwd_hit || rev_hit;
   assign result.rev = !fwd_hit;
   assign result.kind = kind;
   assign result.next_state = nxt;
endmodule

### sv/connection_tracking_table.sv
// top level of the connection tracking flow table
// depends on ctt_pkg, ctt_ram, ctt_match and connection_tracking_table_defines.svh
//
// usage
//  - a request transfer happens at a clock edge with start high and busy low;
//    req_data carries either a packet (lookup and state step) or a create
//  - exactly one result per request, shown on rsp_data for one cycle with
//    rsp_valid high; the receiver cannot stall, so results are never held
//  - create: after the request transfer come hash, bucket fill read,
//    fill check and write, then the result
//  - packet: hash and bucket fill read as for a create, then the ways of
//    the bucket, newest way first, until a hit; each way is one read of the
//    entry memories then one pass through the shared compare and step unit,
//    and a miss ends in a last read state that finds no way left
//  - a new request is taken the cycle the result shows, busy stays high
//    while a request is in flight
//  - after reset the bucket fill memory is cleared one bucket a cycle,
//    all BUCKETS (512) buckets, with busy high; entries themselves are not cleared
//  - a full bucket refuses a create and flags bucket_full
`include "connection_tracking_table_defines.svh"
module connection_tracking_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ctt_pkg::ctt_req_type req_data,
   output logic                 rsp_valid,
   output ctt_pkg::ctt_rsp_type rsp_data
);
   import ctt_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_FILL_RD, S_FILL_WAIT, S_WAY_RD, S_WAY_CMP
   } state_type;

   state_type               state_ff, state_in;
   ctt_req_type             req_ff, req_in;
   logic [BUCKET_BITS-1:0]  bucket_ff, bucket_in;
   logic [BUCKET_BITS-1:0]  clear_ff, clear_in;
   logic [FILL_BITS-1:0]    way_ff, way_in;
   logic [11:0]             count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ctt_rsp_type             rsp_ff, rsp_in;

   // hash of the latched tuple
   logic [31:0] hash_x, hash_p;

   // fill memory ports
   logic                   fill_we;
   logic [BUCKET_BITS-1:0] fill_waddr;
   logic [FILL_BITS-1:0]   fill_wdata, fill_rdata;

   // entry memory ports
   logic                entry_we, ks_we;
   logic [IDX_BITS-1:0] entry_waddr, ks_waddr, entry_raddr;
   logic [63:0]         addr_rdata;
   logic [39:0]         pp_rdata;
   logic [5:0]          ks_wdata, ks_rdata;
   logic [WAY_BITS-1:0] look_way;

   ctt_match_type match;

   assign hash_x = req_ff.src_ip ^ req_ff.dst_ip ^ {16'd0, req_ff.src_port}
                 ^ {16'd0, req_ff.dst_port} ^ {24'd0, req_ff.protocol};
   assign hash_p = hash_x * HASH_MUL;

   // way under test, counted down from the bucket fill
   assign look_way = WAY_BITS'(way_ff - FILL_BITS'(1));
   assign entry_raddr = entry_idx(bucket_ff, look_way);

   ctt_ram #(.WIDTH(FILL_BITS), .DEPTH(BUCKETS)) u_fill_ram (
      .clock(clock), .wr_en(fill_we), .wr_addr(fill_waddr), .wr_data(fill_wdata),
      .rd_addr(bucket_ff), .rd_data(fill_rdata)
   );

   ctt_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_addr_ram (
      .clock(clock), .wr_en(entry_we), .wr_addr(entry_waddr),
      .wr_data({req_ff.src_ip, req_ff.dst_ip}),
      .rd_addr(entry_raddr), .rd_data(addr_rdata)
   );

   ctt_ram #(.WIDTH(40), .DEPTH(ENTRIES)) u_pp_ram (
      .clock(clock), .wr_en(entry_we), .wr_addr(entry_waddr),
      .wr_data({req_ff.src_port, req_ff.dst_port, req_ff.protocol}),
      .rd_addr(entry_raddr), .rd_data(pp_rdata)
   );

   ctt_ram #(.WIDTH(6), .DEPTH(ENTRIES)) u_ks_ram (
      .clock(clock), .wr_en(ks_we), .wr_addr(ks_waddr), .wr_data(ks_wdata),
      .rd_addr(entry_raddr), .rd_data(ks_rdata)
   );

   ctt_match u_match (
      .req(req_ff), .entry_addr(addr_rdata), .entry_pp(pp_rdata),
      .entry_ks(ks_rdata), .result(match)
   );

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      bucket_in = bucket_ff;
      clear_in = clear_ff;
      way_in = way_ff;
      count_in = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      fill_we = 1'b0;
      fill_waddr = bucket_ff;
      fill_wdata = fill_rdata + FILL_BITS'(1);
      entry_we = 1'b0;
      entry_waddr = entry_idx(bucket_ff, WAY_BITS'(fill_rdata));
      ks_we = 1'b0;
      ks_waddr = entry_waddr;
      ks_wdata = {req_ff.conn_kind, req_ff.init_state};

      case (state_ff)
         S_CLEAR: begin
            // zero one bucket fill per cycle
            fill_we = 1'b1;
            fill_waddr = clear_ff;
            fill_wdata = '0;
            clear_in = clear_ff + BUCKET_BITS'(1);
            if (clear_ff == BUCKET_BITS'(BUCKETS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            bucket_in = hash_p[BUCKET_BITS-1:0];
            state_in = S_FILL_RD;
         end
         S_FILL_RD: begin
            state_in = S_FILL_WAIT;
         end
         S_FILL_WAIT: begin
            rsp_in = '0;
            rsp_in.conn_count = count_ff;
            if (req_ff.req_type == REQ_CREATE) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
               if (fill_rdata < FILL_BITS'(WAYS)) begin
                  fill_we = 1'b1;
                  entry_we = 1'b1;
                  ks_we = 1'b1;
                  if (count_ff != COUNT_MAX) count_in = count_ff + 12'd1;
                  rsp_in.created = 1'b1;
                  rsp_in.state_out = req_ff.init_state;
                  rsp_in.match_class = class_of(req_ff.init_state);
                  rsp_in.established = is_est(req_ff.init_state);
                  rsp_in.conn_count = (count_ff != COUNT_MAX) ? count_ff + 12'd1 : count_ff;
               end else begin
                  rsp_in.bucket_full = 1'b1;
               end
            end else begin
               way_in = (fill_rdata > FILL_BITS'(WAYS)) ? FILL_BITS'(WAYS) : fill_rdata;
               state_in = S_WAY_RD;
            end
         end
         S_WAY_RD: begin
            if (way_ff == '0) begin
               // miss over the whole bucket
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.state_out = ST_NONE;
               rsp_in.conn_count = count_ff;
               state_in = S_IDLE;
            end else begin
               state_in = S_WAY_CMP;
            end
         end
         S_WAY_CMP: begin
            if (match.hit) begin
               ks_we = 1'b1;
               ks_waddr = entry_raddr;
               ks_wdata = {match.kind, match.next_state};
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.hit = 1'b1;
               rsp_in.reply_dir = match.rev;
               rsp_in.state_out = match.next_state;
               rsp_in.match_class = class_of(match.next_state);
               rsp_in.established = is_est(match.next_state);
               rsp_in.conn_count = count_ff;
               state_in = S_IDLE;
            end else begin
               way_in = way_ff - FILL_BITS'(1);
               state_in = S_WAY_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clear_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      bucket_ff <= bucket_in;
      way_ff <= way_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // a result only shows once the sequencer is back to idle
   `CTT_ASSERT(a_rsp_idle, clock, reset, rsp_valid |-> !busy, "result while busy")
   // a create never both stores and refuses
   `CTT_ASSERT(a_create_excl, clock, reset, rsp_valid |-> !(rsp_data.created && rsp_data.bucket_full), "created and full")
   // a hit always reports a known match class
   `CTT_ASSERT(a_hit_class, clock, reset, (rsp_valid && rsp_data.hit) |-> (rsp_data.match_class != CLS_UNKNOWN), "hit without class")
   // an accepted request makes the block busy on the next cycle
   `CTT_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accepted request not busy")
   // reset leaves no stray result strobe
   `CTT_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result after reset")
endmodule
